// ===== src/assert_macros.svh =====
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/wee_pkg.sv =====
package wee_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_WINDOWS_DEF = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int SUM_W           = 48;
    localparam int CFG_ADDR_W      = 2;

    localparam logic [15:0] HOP_RST   = 16'd4800;
    localparam logic [15:0] WIN_RST   = 16'd9600;
    localparam logic [15:0] COEFF_RST = 16'd64010;
    localparam logic [15:0] MID_GAIN  = 16'd47186;
    localparam logic [15:0] HIGH_GAIN = 16'd18350;

    localparam logic [CFG_ADDR_W-1:0] CFG_HOP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEFF = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_in;

    typedef struct packed {
        logic [31:0] frame_start;
        logic [15:0] frame_len;
        logic [15:0] rms;
        logic [15:0] low_rms;
        logic [15:0] mid_level;
        logic [15:0] high_level;
        logic [15:0] onset;
        logic        last_frame;
    } t_out;

    typedef struct packed {
        logic             has_frame;
        logic             last;
        logic [31:0]      origin;
        logic [15:0]      len;
        logic [SUM_W-1:0] esum;
        logic [SUM_W-1:0] lsum;
    } t_frame;

endpackage

// ===== src/wee_front.sv =====
module wee_front import wee_pkg::*; #(
    parameter int MAX_WIN = MAX_WINDOWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [15:0]           i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_push,
    output t_frame                o_frame,
    input  logic                  i_full
);

    localparam int IDX_W = $clog2(MAX_WIN);
    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_FILT = 3'd2;
    localparam logic [2:0] F_SQ   = 3'd3;
    localparam logic [2:0] F_ACC  = 3'd4;

    logic [2:0]  r_state;
    logic [15:0] r_hop, r_win, r_coeff;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic        r_last;
    logic signed [23:0] r_lp;
    logic signed [41:0] r_p1, r_p2;
    logic [30:0] r_sq_x, r_sq_l;
    logic [31:0] r_count;
    logic [15:0] r_phase;

    logic             r_open   [MAX_WIN];
    logic [15:0]      r_fill   [MAX_WIN];
    logic [SUM_W-1:0] r_esum   [MAX_WIN];
    logic [SUM_W-1:0] r_lsum   [MAX_WIN];
    logic [31:0]      r_origin [MAX_WIN];

    logic signed [23:0] x24;
    logic signed [15:0] x16, l16;
    logic signed [17:0] c1;
    logic signed [16:0] c2;
    logic signed [41:0] acc;
    logic signed [31:0] sqx_full, sql_full;

    logic             found, have, need_push, go;
    logic [IDX_W-1:0] open_idx, pick;
    logic             opening [MAX_WIN];
    logic             act     [MAX_WIN];
    logic             done    [MAX_WIN];
    logic [15:0]      fill_n  [MAX_WIN];
    logic [SUM_W-1:0] esum_n  [MAX_WIN];
    logic [SUM_W-1:0] lsum_n  [MAX_WIN];
    logic [31:0]      orig_n  [MAX_WIN];
    logic [16:0]      phase_inc;

    assign x24      = {r_x, {(24-SAMPLE_BITS){1'b0}}};
    assign x16      = x24[23:8];
    assign l16      = r_lp[23:8];
    assign c1       = $signed({1'b0, 17'd65536 - {1'b0, r_coeff}});
    assign c2       = $signed({1'b0, r_coeff});
    assign acc      = r_p1 + r_p2 + 42'sd32768;
    assign sqx_full = 32'(x16 * x16);
    assign sql_full = 32'(l16 * l16);
    assign phase_inc = {1'b0, r_phase} + 17'd1;

    always_comb begin
        found    = 1'b0;
        open_idx = '0;
        for (int i = 0; i < MAX_WIN; i++) begin
            if (!found && !r_open[i]) begin
                found    = 1'b1;
                open_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < MAX_WIN; i++) begin
            opening[i] = (r_phase == 16'd0) && found && (open_idx == IDX_W'(i));
            act[i]     = r_open[i] || opening[i];
            if (opening[i]) begin
                fill_n[i] = 16'd1;
            end else if (r_fill[i] != 16'hFFFF) begin
                fill_n[i] = r_fill[i] + 16'd1;
            end else begin
                fill_n[i] = r_fill[i];
            end
            esum_n[i] = (opening[i] ? '0 : r_esum[i]) + SUM_W'(r_sq_x);
            lsum_n[i] = (opening[i] ? '0 : r_lsum[i]) + SUM_W'(r_sq_l);
            orig_n[i] = opening[i] ? r_count : r_origin[i];
            done[i]   = act[i] && (r_last || fill_n[i] >= r_win);
        end
        have = 1'b0;
        pick = '0;
        for (int i = 0; i < MAX_WIN; i++) begin
            if (done[i] && (!have || fill_n[i] > fill_n[pick])) begin
                have = 1'b1;
                pick = IDX_W'(i);
            end
        end
        need_push = have || r_last;
        go        = (r_state == F_ACC) && (!need_push || !i_full);
    end

    assign o_in_ready = (r_state == F_IDLE);
    assign o_push     = go && need_push;

    always_comb begin
        o_frame.has_frame = have;
        o_frame.last      = r_last;
        o_frame.origin    = orig_n[pick];
        o_frame.len       = fill_n[pick];
        o_frame.esum      = esum_n[pick];
        o_frame.lsum      = lsum_n[pick];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop   <= HOP_RST;
            r_win   <= WIN_RST;
            r_coeff <= COEFF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HOP:   r_hop   <= i_cfg_wdata;
                CFG_WIN:   r_win   <= i_cfg_wdata;
                CFG_COEFF: r_coeff <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_lp    <= '0;
            r_count <= '0;
            r_phase <= '0;
            for (int i = 0; i < MAX_WIN; i++) begin
                r_open[i]   <= 1'b0;
                r_fill[i]   <= '0;
                r_esum[i]   <= '0;
                r_lsum[i]   <= '0;
                r_origin[i] <= '0;
            end
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_in_data.sample;
                        r_last  <= i_in_data.last_sample;
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_p1    <= 42'(c1 * x24);
                    r_p2    <= 42'(c2 * r_lp);
                    r_sq_x  <= sqx_full[30:0];
                    r_state <= F_FILT;
                end
                F_FILT: begin
                    r_lp    <= acc[39:16];
                    r_state <= F_SQ;
                end
                F_SQ: begin
                    r_sq_l  <= sql_full[30:0];
                    r_state <= F_ACC;
                end
                F_ACC: begin
                    if (go) begin
                        r_state <= F_IDLE;
                        if (r_last) begin
                            r_lp    <= '0;
                            r_count <= '0;
                            r_phase <= '0;
                            for (int i = 0; i < MAX_WIN; i++) begin
                                r_open[i]   <= 1'b0;
                                r_fill[i]   <= '0;
                                r_esum[i]   <= '0;
                                r_lsum[i]   <= '0;
                                r_origin[i] <= '0;
                            end
                        end else begin
                            r_count <= r_count + 32'd1;
                            r_phase <= (phase_inc >= {1'b0, r_hop}) ? 16'd0 : phase_inc[15:0];
                            for (int i = 0; i < MAX_WIN; i++) begin
                                if (act[i]) begin
                                    r_fill[i]   <= fill_n[i];
                                    r_esum[i]   <= esum_n[i];
                                    r_lsum[i]   <= lsum_n[i];
                                    r_origin[i] <= orig_n[i];
                                    r_open[i]   <= !(have && (pick == IDX_W'(i) || done[i]));
                                end
                            end
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== src/wee_queue.sv =====
module wee_queue import wee_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_avail,
    output t_frame o_data
);

    localparam int PTR_W = $clog2(DEPTH);

    t_frame           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH-1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH-1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

endmodule

// ===== src/wee_back.sv =====
`include "assert_macros.svh"
module wee_back import wee_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_avail,
    output logic   o_pop,
    input  t_frame i_frame,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_out   o_out_data
);

    localparam int DIV_W      = SUM_W + 2;
    localparam int DIV_STEPS  = DIV_W;
    localparam int SQRT_STEPS = 17;
    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_DIV   = 3'd1;
    localparam logic [2:0] B_SQRT  = 3'd2;
    localparam logic [2:0] B_SCALE = 3'd3;
    localparam logic [2:0] B_OUT   = 3'd4;

    logic [2:0]       r_state;
    logic [5:0]       r_cnt;
    logic             r_last;
    logic [31:0]      r_origin;
    logic [15:0]      r_len;
    logic [15:0]      r_prev;
    logic [DIV_W-1:0] r_dvd [2];
    logic [15:0]      r_rem [2];
    logic [33:0]      r_q   [2];
    logic [33:0]      r_sv    [3];
    logic [19:0]      r_srem  [3];
    logic [16:0]      r_root  [3];
    t_out             r_out;

    logic [16:0] dsh   [2];
    logic        dge   [2];
    logic [19:0] ssh   [3];
    logic [19:0] trial [3];
    logic        sge   [3];
    logic [15:0] rms_s, lrms_s;
    logic [33:0] mid_p, high_p;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            dsh[k] = {r_rem[k], r_dvd[k][DIV_W-1]};
            dge[k] = dsh[k] >= {1'b0, r_len};
        end
        for (int k = 0; k < 3; k++) begin
            ssh[k]   = {r_srem[k][17:0], r_sv[k][33:32]};
            trial[k] = {1'b0, r_root[k], 2'b01};
            sge[k]   = ssh[k] >= trial[k];
        end
        rms_s  = r_root[0][16] ? 16'hFFFF : r_root[0][15:0];
        lrms_s = r_root[1][16] ? 16'hFFFF : r_root[1][15:0];
        mid_p  = 34'(r_root[2] * MID_GAIN) + 34'd32768;
        high_p = 34'(r_root[2] * HIGH_GAIN) + 34'd32768;
    end

    assign o_pop       = (r_state == B_IDLE) && i_avail;
    assign o_out_valid = (r_state == B_OUT);
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_prev  <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_avail) begin
                        if (i_frame.has_frame) begin
                            r_last   <= i_frame.last;
                            r_origin <= i_frame.origin;
                            r_len    <= i_frame.len;
                            r_dvd[0] <= {i_frame.esum, 2'b00};
                            r_dvd[1] <= {i_frame.lsum, 2'b00};
                            for (int k = 0; k < 2; k++) begin
                                r_rem[k] <= '0;
                                r_q[k]   <= '0;
                            end
                            r_cnt   <= '0;
                            r_state <= B_DIV;
                        end else begin
                            r_prev <= '0;
                        end
                    end
                end
                B_DIV: begin
                    for (int k = 0; k < 2; k++) begin
                        r_rem[k] <= dge[k] ? 16'(dsh[k] - {1'b0, r_len}) : dsh[k][15:0];
                        r_q[k]   <= {r_q[k][32:0], dge[k]};
                        r_dvd[k] <= {r_dvd[k][DIV_W-2:0], 1'b0};
                    end
                    if (r_cnt == 6'(DIV_STEPS-1)) begin
                        r_cnt   <= '0;
                        r_state <= B_SQRT;
                        r_sv[0] <= {r_q[0][32:0], dge[0]};
                        r_sv[1] <= {r_q[1][32:0], dge[1]};
                        for (int k = 0; k < 3; k++) begin
                            r_srem[k] <= '0;
                            r_root[k] <= '0;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                B_SQRT: begin
                    if (r_cnt == 6'd0) begin
                        r_sv[2] <= (r_sv[0] > r_sv[1]) ? r_sv[0] - r_sv[1] : '0;
                        r_cnt   <= 6'd1;
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            r_srem[k] <= sge[k] ? ssh[k] - trial[k] : ssh[k];
                            r_root[k] <= {r_root[k][15:0], sge[k]};
                            r_sv[k]   <= {r_sv[k][31:0], 2'b00};
                        end
                        if (r_cnt == 6'(SQRT_STEPS)) begin
                            r_state <= B_SCALE;
                        end
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                B_SCALE: begin
                    r_out.frame_start <= r_origin;
                    r_out.frame_len   <= r_len;
                    r_out.rms         <= rms_s;
                    r_out.low_rms     <= lrms_s;
                    r_out.mid_level   <= (mid_p[33:16] > 18'hFFFF) ? 16'hFFFF : mid_p[31:16];
                    r_out.high_level  <= (high_p[33:16] > 18'hFFFF) ? 16'hFFFF : high_p[31:16];
                    r_out.onset       <= (rms_s > r_prev) ? rms_s - r_prev : 16'd0;
                    r_out.last_frame  <= r_last;
                    r_prev            <= r_last ? 16'd0 : rms_s;
                    r_state           <= B_OUT;
                end
                B_OUT: begin
                    if (i_out_ready) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLY(a_onset_le_rms, i_clk, i_rst_n, o_out_valid, o_out_data.onset <= o_out_data.rms)
    `ASSERT_IMPLY(a_mid_ge_high, i_clk, i_rst_n, o_out_valid, o_out_data.mid_level >= o_out_data.high_level)
    `ASSERT_IMPLY(a_len_nonzero, i_clk, i_rst_n, o_out_valid, o_out_data.frame_len != 16'd0)

endmodule

// ===== src/windowed_energy_envelope.sv =====
// Channel   Direction  Handshake                     Payload
// sample    in         i_in_valid / o_in_ready       i_in_data (t_in)
// result    out        o_out_valid / i_out_ready     o_out_data (t_out)
// config    in         i_cfg_we                      i_cfg_addr, i_cfg_wdata
//
// Each sample goes through capture, filter multiply, filter round, filtered
// square, then window update and frame pick; the next sample waits for it.
// Each frame goes through a 50-step two-lane divider, then three 17-step
// square-root lanes, then scaling and output wait; the next frame waits for it.
// A two-entry queue between the halves stalls sample input only when full.
// Reset is synchronous and active low; it clears control, config and window state, not datapath or queue storage.
module windowed_energy_envelope import wee_pkg::*; #(
    parameter int MAX_OPEN_WINDOWS = MAX_WINDOWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [15:0]           i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data
);

    logic   push, full, pop, avail;
    t_frame push_data, pop_data;

    wee_front #(.MAX_WIN(MAX_OPEN_WINDOWS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_frame     (push_data),
        .i_full      (full)
    );

    wee_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_data  (pop_data)
    );

    wee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (avail),
        .o_pop       (pop),
        .i_frame     (pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
